### rtl/glyph_lru_cache_core_assert.svh
// Assertion macros used by the glyph cache port checker.
`ifndef GLYPH_LRU_CACHE_CORE_ASSERT_SVH
`define GLYPH_LRU_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/glc_pkg.sv
// Types and constants of the glyph cache.
`timescale 1ns / 1ps

package glc_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned FONT_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned DROP_W  = 5;
  localparam int unsigned STAMP_W = 32;

  localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam int unsigned OUT_HIT_BIT     = 0;
  localparam int unsigned OUT_FILLED_BIT  = 21;
  localparam int unsigned OUT_EVICTED_BIT = 22;
  localparam int unsigned OUT_DROP_LSB    = 52;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic [SIZE_W-1:0] fill_height;
    logic [SIZE_W-1:0] fill_width;
    logic              fill_ok;
    logic [CP_W-1:0]   code_point;
    logic [FONT_W-1:0] font_handle;
  } in_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [DROP_W-1:0] dropped_count;
    logic [CP_W-1:0]   evicted_code_point;
    logic [FONT_W-1:0] evicted_font;
    logic              evicted;
    logic              filled;
    logic [SIZE_W-1:0] glyph_height;
    logic [SIZE_W-1:0] glyph_width;
    logic [SLOT_W-1:0] slot_index;
    logic              hit;
  } out_t;

  // Entry payload kept in the key memory.
  typedef struct packed {
    logic [FONT_W-1:0] font;
    logic [CP_W-1:0]   cp;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } entry_t;

endpackage

### rtl/glyph_lru_cache_core.sv
// Fully associative glyph cache with least-recently-used replacement.
`timescale 1ns / 1ps

// A request is a lookup or fill keyed by font handle and code point, or a drop of every entry
// of one font. Slots are checked one per cycle through a single read port on the entry and
// stamp memories that feeds one key comparator and one stamp comparator. A lookup that hits
// slot k stops the scan there, while a miss or fill scans every slot and then passes through
// the fill state, and a drop scans every slot. The result waits in an output register, so
// the next item is taken while it is still unread; the block is ready again only once the
// previous result has moved into that register.
module glyph_lru_cache_core #(
  parameter int unsigned SLOTS = glc_pkg::SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // font_handle, code_point, fill_ok, fill_width, fill_height, zero pad
  input  logic [glc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, slot_index, glyph_width, glyph_height, filled, evicted, evicted_font,
  // evicted_code_point, dropped_count, zero pad
  output logic [glc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]                     state_q, state_d;
  glc_pkg::in_t                   req_q;
  logic                           drop_q;
  logic [IW-1:0]                  scan_idx_q;
  logic [IW-1:0]                  chk_idx_q;
  logic [SLOTS-1:0]               valid_q;
  logic [glc_pkg::STAMP_W-1:0]    tick_q;
  logic                           have_empty_q;
  logic [IW-1:0]                  vic_idx_q;
  logic [glc_pkg::STAMP_W-1:0]    oldest_q;
  logic [glc_pkg::FONT_W-1:0]     vic_font_q;
  logic [glc_pkg::CP_W-1:0]       vic_cp_q;
  logic [CW-1:0]                  cnt_q, cnt_d;
  glc_pkg::out_t                  res_q, res_d;
  glc_pkg::out_t                  out_q;
  logic                           out_valid_q;

  glc_pkg::entry_t                key_mem [SLOTS];
  logic [glc_pkg::STAMP_W-1:0]    stamp_mem [SLOTS];
  glc_pkg::entry_t                key_rd_q;
  logic [glc_pkg::STAMP_W-1:0]    stamp_rd_q;

  logic [IW-1:0]                  rd_addr;
  logic                           key_we;
  logic                           stamp_we;
  logic [IW-1:0]                  stamp_waddr;
  glc_pkg::entry_t                key_wdata;

  logic                           in_acc;
  logic                           out_load;
  logic                           last_slot;
  logic                           cur_valid;
  logic                           font_eq;
  logic                           key_hit;
  logic                           stamp_lt;
  logic                           take_victim;
  logic [glc_pkg::STAMP_W-1:0]    tick_inc;
  logic [31:0]                    chk_slot_ext;
  logic [31:0]                    vic_slot_ext;
  logic [31:0]                    cnt_ext;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  assign last_slot   = (chk_idx_q == LAST_IDX);
  assign cur_valid   = valid_q[chk_idx_q];
  assign font_eq     = (key_rd_q.font == req_q.font_handle);
  assign key_hit     = cur_valid && font_eq && (key_rd_q.cp == req_q.code_point);
  assign stamp_lt    = (stamp_rd_q < oldest_q);
  assign take_victim = !cur_valid || (!have_empty_q && (stamp_lt || (chk_idx_q == '0)));
  assign tick_inc    = tick_q + 32'd1;

  assign chk_slot_ext = 32'(chk_idx_q);
  assign vic_slot_ext = 32'(vic_idx_q);
  assign cnt_ext      = 32'(cnt_d);

  always_comb begin
    cnt_d = cnt_q;
    if ((state_q == ST_SCAN) && drop_q && cur_valid && font_eq) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_comb begin
    rd_addr = '0;
    if (state_q == ST_SCAN) begin
      rd_addr = scan_idx_q;
    end
  end

  assign key_we      = (state_q == ST_FILL) && req_q.fill_ok;
  assign stamp_we    = key_we || ((state_q == ST_SCAN) && !drop_q && key_hit);
  assign stamp_waddr = (state_q == ST_SCAN) ? chk_idx_q : vic_idx_q;

  always_comb begin
    key_wdata.font   = req_q.font_handle;
    key_wdata.cp     = req_q.code_point;
    key_wdata.width  = req_q.fill_width;
    key_wdata.height = req_q.fill_height;
  end

  always_comb begin
    res_d = res_q;
    if (state_q == ST_SCAN) begin
      if (drop_q) begin
        res_d               = '0;
        res_d.dropped_count = cnt_ext[glc_pkg::DROP_W-1:0];
      end else if (key_hit) begin
        res_d              = '0;
        res_d.hit          = 1'b1;
        res_d.slot_index   = chk_slot_ext[glc_pkg::SLOT_W-1:0];
        res_d.glyph_width  = key_rd_q.width;
        res_d.glyph_height = key_rd_q.height;
      end
    end
    if (state_q == ST_FILL) begin
      res_d = '0;
      if (req_q.fill_ok) begin
        res_d.slot_index   = vic_slot_ext[glc_pkg::SLOT_W-1:0];
        res_d.glyph_width  = req_q.fill_width;
        res_d.glyph_height = req_q.fill_height;
        res_d.filled       = 1'b1;
        if (!have_empty_q) begin
          res_d.evicted            = 1'b1;
          res_d.evicted_font       = vic_font_q;
          res_d.evicted_code_point = vic_cp_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[vic_idx_q] <= key_wdata;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= tick_inc;
    end
    stamp_rd_q <= stamp_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (drop_q) begin
          if (last_slot) begin
            state_d = ST_RESP;
          end
        end else if (key_hit) begin
          state_d = ST_RESP;
        end else if (last_slot) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      scan_idx_q   <= '0;
      chk_idx_q    <= '0;
      have_empty_q <= 1'b0;
      vic_idx_q    <= '0;
      oldest_q     <= glc_pkg::STAMP_MAX;
      cnt_q        <= '0;
      drop_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            drop_q       <= s_axis_tuser;
            scan_idx_q   <= IW'(1);
            chk_idx_q    <= '0;
            have_empty_q <= 1'b0;
            vic_idx_q    <= '0;
            oldest_q     <= glc_pkg::STAMP_MAX;
            cnt_q        <= '0;
          end
        end
        ST_SCAN: begin
          chk_idx_q <= scan_idx_q;
          if (scan_idx_q != LAST_IDX) begin
            scan_idx_q <= scan_idx_q + IW'(1);
          end
          if (drop_q) begin
            cnt_q <= cnt_d;
            if (cur_valid && font_eq) begin
              valid_q[chk_idx_q] <= 1'b0;
            end
          end else if (key_hit) begin
            tick_q <= tick_inc;
          end else if (take_victim) begin
            vic_idx_q    <= chk_idx_q;
            have_empty_q <= have_empty_q || !cur_valid;
            if (cur_valid) begin
              oldest_q <= stamp_rd_q;
            end
          end
        end
        ST_FILL: begin
          if (req_q.fill_ok) begin
            valid_q[vic_idx_q] <= 1'b1;
            tick_q             <= tick_inc;
          end
        end
        ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= s_axis_tdata;
    end
    if ((state_q == ST_SCAN) && !drop_q && !key_hit && take_victim && cur_valid) begin
      vic_font_q <= key_rd_q.font;
      vic_cp_q   <= key_rd_q.cp;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

### rtl/glc_port_checker.sv
// Port-level checks of the glyph cache, bound to the top level.
`timescale 1ns / 1ps
`include "glyph_lru_cache_core_assert.svh"

module glc_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [glc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic res_hit;
  logic res_filled;
  logic res_evicted;
  logic res_dropped;

  assign res_hit     = m_axis_tdata[glc_pkg::OUT_HIT_BIT];
  assign res_filled  = m_axis_tdata[glc_pkg::OUT_FILLED_BIT];
  assign res_evicted = m_axis_tdata[glc_pkg::OUT_EVICTED_BIT];
  assign res_dropped =
    |m_axis_tdata[glc_pkg::OUT_DROP_LSB +: glc_pkg::DROP_W];

  `GLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed.")
  `GLC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Ready right after an item was taken.")
  `GLC_ASSERT_IMP(a_hit_exclusive, clk_i, rst_ni, m_axis_tvalid && res_hit, !res_filled && !res_evicted && !res_dropped, "Hit result carries fill or drop fields.")
  `GLC_ASSERT_IMP(a_evict_needs_fill, clk_i, rst_ni, m_axis_tvalid && res_evicted, res_filled && !res_dropped, "Eviction without a fill.")

endmodule

bind glyph_lru_cache_core glc_port_checker u_glc_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
